// ===== rtl/rmis_pkg.sv =====
// shared types, codes and helpers for the randomized independent set engine
`default_nettype none
package rmis_pkg;

    localparam int C_MAX_VERTICES  = 1024;
    localparam int C_MAX_EDGES     = 8192;
    localparam int C_FRACTION_BITS = 24;

    localparam logic [31:0] C_LFSR_MASK = 32'h8020_0003;

    localparam logic [1:0] OP_LOAD_OFFSET = 2'd0;
    localparam logic [1:0] OP_LOAD_EDGE   = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;
    localparam logic [1:0] OP_READ_VERTEX = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
    localparam logic [2:0] REG_DEG_THRESH   = 3'd1;
    localparam logic [2:0] REG_INIT_DESIRE  = 3'd2;
    localparam logic [2:0] REG_MIN_DESIRE   = 3'd3;
    localparam logic [2:0] REG_SEED         = 3'd4;
    localparam logic [2:0] REG_MAX_ROUNDS   = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_CHECK,
        S_C_RD,
        S_C_LO,
        S_C_HI,
        S_C_EDGE,
        S_C_TGT,
        S_C_NBR,
        S_D_RD,
        S_D_LO,
        S_D_HI,
        S_D_EDGE,
        S_D_TGT,
        S_D_NBR,
        S_DONE
    } t_state;

    function automatic logic [31:0] lfsr_step(input logic [31:0] x);
        logic [31:0] y;
        y = x >> 1;
        if (x[0]) begin
            y = y ^ C_LFSR_MASK;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/randomized_mis_engine.sv =====
// randomized maximal independent set engine: csr graph stores, round sequencer
// load offset, load edge: store written when accepted; read vertex: store read
// run: store clearing over MAX_VERTICES entries, then per round a commit phase
//   over active vertices and their edges and a join phase over committed ones,
//   through the single read port of each store, walked by one sequencer
// no new item is taken until the result is loaded into the output register
// synchronous active low reset clears control state and loads register defaults
`default_nettype none
module randomized_mis_engine #(
    parameter int MAX_VERTICES  = rmis_pkg::C_MAX_VERTICES,
    parameter int MAX_EDGES     = rmis_pkg::C_MAX_EDGES,
    parameter int FRACTION_BITS = rmis_pkg::C_FRACTION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [12:0] i_index,
    input  wire logic [13:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_in_set,
    output logic      [15:0] o_rounds,
    output logic      [1:0]  o_status
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int OAW = $clog2(MAX_VERTICES + 1);
    localparam int FB  = FRACTION_BITS;
    localparam int SW  = FB + 5;

    // configuration
    logic [10:0]       r_cfg_vcount;
    logic [3:0]        r_cfg_thresh;
    logic signed [5:0] r_cfg_init;
    logic signed [5:0] r_cfg_min;
    logic [31:0]       r_cfg_seed;
    logic [15:0]       r_cfg_maxr;
    logic              cfg_wr;

    // stores
    logic [13:0]   r_off_mem [MAX_VERTICES + 1];
    logic [VW-1:0] r_tgt_mem [MAX_EDGES];
    logic [5:0]    r_des_mem [2 * MAX_VERTICES];
    logic          r_act_mem [MAX_VERTICES];
    logic          r_com_mem [MAX_VERTICES];
    logic          r_mem_mem [MAX_VERTICES];

    logic [13:0]   r_off_q;
    logic [VW-1:0] r_tgt_q;
    logic [5:0]    r_des_q;
    logic          r_act_q;
    logic          r_com_q;
    logic          r_mem_q;

    logic           off_we, tgt_we, des_we, act_we, com_we, mem_we;
    logic [OAW-1:0] off_wa, off_ra;
    logic [13:0]    off_wd;
    logic [EW-1:0]  tgt_wa, tgt_ra;
    logic [VW-1:0]  tgt_wd;
    logic [VW:0]    des_wa, des_ra;
    logic [5:0]     des_wd;
    logic [VW-1:0]  act_wa, act_ra, com_wa, com_ra, mem_wa, mem_ra;
    logic           act_wd, com_wd, mem_wd;

    // sequencer state
    rmis_pkg::t_state r_state, n_state;
    logic [VW:0]   r_i, n_i;
    logic [EW:0]   r_e, n_e;
    logic [EW:0]   r_hi, n_hi;
    logic [SW-1:0] r_sum, n_sum;
    logic [5:0]    r_di, n_di;
    logic          r_tok, n_tok;
    logic          r_still, n_still;
    logic          r_mnb, n_mnb;
    logic          r_par, n_par;
    logic [31:0]   r_lfsr, n_lfsr;
    logic [15:0]   r_round, n_round;
    logic [VW:0]   r_cnt, n_cnt;
    logic          r_ran, n_ran;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_res_inset, n_res_inset;
    logic          r_out_valid, n_out_valid;
    logic          r_o_in_set, n_o_in_set;
    logic [15:0]   r_o_rounds, n_o_rounds;
    logic [1:0]    r_o_status, n_o_status;

    logic              accept;
    logic [VW:0]       n_vert;
    logic signed [5:0] dlow, d0;
    logic [31:0]       lfsr_next;
    logic [FB-1:0]     draw;
    logic [EW:0]       off_clamped;
    logic [SW-1:0]     thr_full;
    logic [VW-1:0]     vi;

    function automatic logic [FB:0] weight(input logic [5:0] d);
        logic signed [7:0] s;
        s = signed'(8'(FB)) + signed'({{2{d[5]}}, d});
        if (s < 0) begin
            return '0;
        end
        return (FB + 1)'(1) << s[5:0];
    endfunction

    function automatic logic [5:0] next_desire(input logic [5:0] d, input logic down,
                                               input logic signed [5:0] lo);
        logic signed [6:0] t;
        t = signed'({d[5], d});
        if (down) begin
            t = t - 7'sd1;
            if (t < signed'({lo[5], lo})) begin
                return lo;
            end
        end else begin
            t = t + 7'sd1;
            if (t > -7'sd1) begin
                return 6'h3f;
            end
        end
        return t[5:0];
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_vcount <= 11'd1;
            r_cfg_thresh <= 4'd2;
            r_cfg_init   <= -6'sd1;
            r_cfg_min    <= -6'sd24;
            r_cfg_seed   <= 32'd4;
            r_cfg_maxr   <= 16'd4096;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                rmis_pkg::REG_VERTEX_COUNT: r_cfg_vcount <= pwdata[10:0];
                rmis_pkg::REG_DEG_THRESH:   r_cfg_thresh <= pwdata[3:0];
                rmis_pkg::REG_INIT_DESIRE:  r_cfg_init   <= signed'(pwdata[5:0]);
                rmis_pkg::REG_MIN_DESIRE:   r_cfg_min    <= signed'(pwdata[5:0]);
                rmis_pkg::REG_SEED:         r_cfg_seed   <= pwdata;
                rmis_pkg::REG_MAX_ROUNDS:   r_cfg_maxr   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rmis_pkg::REG_VERTEX_COUNT: prdata = 32'(r_cfg_vcount);
            rmis_pkg::REG_DEG_THRESH:   prdata = 32'(r_cfg_thresh);
            rmis_pkg::REG_INIT_DESIRE:  prdata = 32'(unsigned'(r_cfg_init));
            rmis_pkg::REG_MIN_DESIRE:   prdata = 32'(unsigned'(r_cfg_min));
            rmis_pkg::REG_SEED:         prdata = r_cfg_seed;
            rmis_pkg::REG_MAX_ROUNDS:   prdata = 32'(r_cfg_maxr);
            default:                    prdata = '0;
        endcase
    end

    // derived run settings
    assign n_vert = (32'(r_cfg_vcount) > 32'(MAX_VERTICES)) ?
                    (VW + 1)'(MAX_VERTICES) : (VW + 1)'(r_cfg_vcount);

    always_comb begin
        dlow = (r_cfg_min >= 6'sd0) ? -6'sd1 : r_cfg_min;
        d0   = (r_cfg_init > 6'sd0) ? 6'sd0 : r_cfg_init;
        if (d0 < dlow) begin
            d0 = dlow;
        end
    end

    assign lfsr_next   = rmis_pkg::lfsr_step(r_lfsr);
    assign draw        = lfsr_next[31 -: FB];
    assign off_clamped = (32'(r_off_q) > 32'(MAX_EDGES)) ?
                         (EW + 1)'(MAX_EDGES) : (EW + 1)'(r_off_q);
    assign thr_full    = SW'(r_cfg_thresh) << FB;
    assign vi          = r_i[VW-1:0];

    assign accept   = i_valid & ~o_stall;
    assign o_stall  = (r_state != rmis_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_in_set = r_o_in_set;
    assign o_rounds = r_o_rounds;
    assign o_status = r_o_status;

    // stores, registered reads
    always_ff @(posedge i_clk) begin
        if (off_we) r_off_mem[off_wa] <= off_wd;
        if (tgt_we) r_tgt_mem[tgt_wa] <= tgt_wd;
        if (des_we) r_des_mem[des_wa] <= des_wd;
        if (act_we) r_act_mem[act_wa] <= act_wd;
        if (com_we) r_com_mem[com_wa] <= com_wd;
        if (mem_we) r_mem_mem[mem_wa] <= mem_wd;
        r_off_q <= r_off_mem[off_ra];
        r_tgt_q <= r_tgt_mem[tgt_ra];
        r_des_q <= r_des_mem[des_ra];
        r_act_q <= r_act_mem[act_ra];
        r_com_q <= r_com_mem[com_ra];
        r_mem_q <= r_mem_mem[mem_ra];
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmis_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ran       <= 1'b0;
            r_round     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ran       <= n_ran;
            r_round     <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_e          <= n_e;
        r_hi         <= n_hi;
        r_sum        <= n_sum;
        r_di         <= n_di;
        r_tok        <= n_tok;
        r_still      <= n_still;
        r_mnb        <= n_mnb;
        r_par        <= n_par;
        r_lfsr       <= n_lfsr;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_inset  <= n_res_inset;
        r_o_in_set   <= n_o_in_set;
        r_o_rounds   <= n_o_rounds;
        r_o_status   <= n_o_status;
    end

    // next state and store control
    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_e          = r_e;
        n_hi         = r_hi;
        n_sum        = r_sum;
        n_di         = r_di;
        n_tok        = r_tok;
        n_still      = r_still;
        n_mnb        = r_mnb;
        n_par        = r_par;
        n_lfsr       = r_lfsr;
        n_round      = r_round;
        n_cnt        = r_cnt;
        n_ran        = r_ran;
        n_res_status = r_res_status;
        n_res_inset  = r_res_inset;
        n_out_valid  = r_out_valid & i_stall;
        n_o_in_set   = r_o_in_set;
        n_o_rounds   = r_o_rounds;
        n_o_status   = r_o_status;

        off_we = 1'b0; off_wa = OAW'(i_index); off_wd = i_value;
        off_ra = OAW'(r_i);
        tgt_we = 1'b0; tgt_wa = EW'(i_index); tgt_wd = VW'(i_value);
        tgt_ra = r_e[EW-1:0];
        des_we = 1'b0; des_wa = {~r_par, vi}; des_wd = '0;
        des_ra = {r_par, vi};
        act_we = 1'b0; act_wa = vi; act_wd = 1'b0; act_ra = vi;
        com_we = 1'b0; com_wa = vi; com_wd = 1'b0; com_ra = vi;
        mem_we = 1'b0; mem_wa = vi; mem_wd = 1'b0; mem_ra = vi;

        unique case (r_state)
            rmis_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_inset  = 1'b0;
                    n_res_status = rmis_pkg::STATUS_OK;
                    unique case (i_operation)
                        rmis_pkg::OP_LOAD_OFFSET: begin
                            if (32'(i_index) <= 32'(MAX_VERTICES)) begin
                                off_we = 1'b1;
                            end else begin
                                n_res_status = rmis_pkg::STATUS_RANGE;
                            end
                            n_state = rmis_pkg::S_DONE;
                        end
                        rmis_pkg::OP_LOAD_EDGE: begin
                            if (32'(i_index) < 32'(MAX_EDGES) &&
                                32'(i_value) < 32'(MAX_VERTICES)) begin
                                tgt_we = 1'b1;
                            end else begin
                                n_res_status = rmis_pkg::STATUS_RANGE;
                            end
                            n_state = rmis_pkg::S_DONE;
                        end
                        rmis_pkg::OP_RUN: begin
                            n_ran   = 1'b1;
                            n_lfsr  = (r_cfg_seed != 32'd0) ? r_cfg_seed : 32'd1;
                            n_round = '0;
                            n_cnt   = n_vert;
                            n_i     = '0;
                            n_par   = 1'b0;
                            n_state = rmis_pkg::S_CLEAR;
                        end
                        rmis_pkg::OP_READ_VERTEX: begin
                            mem_ra = VW'(i_index);
                            n_tok  = r_ran && (32'(i_index) < 32'(n_vert));
                            if (32'(i_index) >= 32'(n_vert)) begin
                                n_res_status = rmis_pkg::STATUS_RANGE;
                            end
                            n_state = rmis_pkg::S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            rmis_pkg::S_READ: begin
                n_res_inset = r_tok & r_mem_q;
                n_state     = rmis_pkg::S_DONE;
            end
            rmis_pkg::S_CLEAR: begin
                act_we = 1'b1; act_wd = (r_i < n_vert);
                mem_we = 1'b1; mem_wd = 1'b0;
                des_we = 1'b1; des_wa = {1'b0, vi}; des_wd = unsigned'(d0);
                if (r_i == (VW + 1)'(MAX_VERTICES - 1)) begin
                    n_state = rmis_pkg::S_CHECK;
                end else begin
                    n_i = r_i + (VW + 1)'(1);
                end
            end
            rmis_pkg::S_CHECK: begin
                n_i = '0;
                if (r_cnt == '0) begin
                    n_res_status = rmis_pkg::STATUS_OK;
                    n_state      = rmis_pkg::S_DONE;
                end else if (r_round >= r_cfg_maxr) begin
                    n_res_status = rmis_pkg::STATUS_LIMIT;
                    n_state      = rmis_pkg::S_DONE;
                end else begin
                    n_state = rmis_pkg::S_C_RD;
                end
            end
            // commit draw and desire update
            rmis_pkg::S_C_RD: begin
                if (r_i == n_vert) begin
                    n_i     = '0;
                    n_state = rmis_pkg::S_D_RD;
                end else begin
                    n_state = rmis_pkg::S_C_LO;
                end
            end
            rmis_pkg::S_C_LO: begin
                com_we = 1'b1;
                if (!r_act_q) begin
                    com_wd  = 1'b0;
                    n_i     = r_i + (VW + 1)'(1);
                    n_state = rmis_pkg::S_C_RD;
                end else begin
                    n_lfsr  = lfsr_next;
                    com_wd  = ({1'b0, draw} < weight(r_des_q));
                    n_di    = r_des_q;
                    n_e     = off_clamped;
                    n_sum   = '0;
                    off_ra  = OAW'(r_i + (VW + 1)'(1));
                    n_state = rmis_pkg::S_C_HI;
                end
            end
            rmis_pkg::S_C_HI: begin
                n_hi    = (off_clamped < r_e) ? r_e : off_clamped;
                n_state = rmis_pkg::S_C_EDGE;
            end
            rmis_pkg::S_C_EDGE: begin
                if (r_e >= r_hi) begin
                    des_we  = 1'b1;
                    des_wd  = next_desire(r_di, r_sum >= thr_full, dlow);
                    n_i     = r_i + (VW + 1)'(1);
                    n_state = rmis_pkg::S_C_RD;
                end else begin
                    n_state = rmis_pkg::S_C_TGT;
                end
            end
            rmis_pkg::S_C_TGT: begin
                n_tok   = ((VW + 1)'(r_tgt_q) < n_vert);
                act_ra  = r_tgt_q;
                des_ra  = {r_par, r_tgt_q};
                n_state = rmis_pkg::S_C_NBR;
            end
            rmis_pkg::S_C_NBR: begin
                if (r_tok && r_act_q && !r_sum[SW-1]) begin
                    n_sum = r_sum + SW'(weight(r_des_q));
                end
                n_e     = r_e + (EW + 1)'(1);
                n_state = rmis_pkg::S_C_EDGE;
            end
            // join and retire
            rmis_pkg::S_D_RD: begin
                if (r_i == n_vert) begin
                    n_par   = ~r_par;
                    n_round = r_round + 16'd1;
                    n_state = rmis_pkg::S_CHECK;
                end else begin
                    n_state = rmis_pkg::S_D_LO;
                end
            end
            rmis_pkg::S_D_LO: begin
                if (!r_com_q) begin
                    n_i     = r_i + (VW + 1)'(1);
                    n_state = rmis_pkg::S_D_RD;
                end else begin
                    n_e     = off_clamped;
                    n_still = 1'b1;
                    n_mnb   = 1'b0;
                    off_ra  = OAW'(r_i + (VW + 1)'(1));
                    n_state = rmis_pkg::S_D_HI;
                end
            end
            rmis_pkg::S_D_HI: begin
                n_hi    = (off_clamped < r_e) ? r_e : off_clamped;
                n_state = rmis_pkg::S_D_EDGE;
            end
            rmis_pkg::S_D_EDGE: begin
                if (r_e >= r_hi) begin
                    if (r_mnb || r_still) begin
                        act_we = 1'b1;
                        act_wd = 1'b0;
                        n_cnt  = r_cnt - (VW + 1)'(1);
                    end
                    if (r_still) begin
                        mem_we = 1'b1;
                        mem_wd = 1'b1;
                    end
                    n_i     = r_i + (VW + 1)'(1);
                    n_state = rmis_pkg::S_D_RD;
                end else begin
                    n_state = rmis_pkg::S_D_TGT;
                end
            end
            rmis_pkg::S_D_TGT: begin
                n_tok   = ((VW + 1)'(r_tgt_q) < n_vert);
                mem_ra  = r_tgt_q;
                com_ra  = r_tgt_q;
                n_state = rmis_pkg::S_D_NBR;
            end
            rmis_pkg::S_D_NBR: begin
                if (r_tok) begin
                    if (r_mem_q) begin
                        n_mnb = 1'b1;
                    end
                    if (r_mem_q || r_com_q) begin
                        n_still = 1'b0;
                    end
                end
                n_e     = r_e + (EW + 1)'(1);
                n_state = rmis_pkg::S_D_EDGE;
            end
            rmis_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_in_set  = r_res_inset;
                    n_o_rounds  = r_round;
                    n_o_status  = r_res_status;
                    n_state     = rmis_pkg::S_IDLE;
                end
            end
            default: n_state = rmis_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/randomized_mis_engine_tb.sv =====
// testbench for the randomized maximal independent set engine: directed and random graphs
`default_nettype none
module randomized_mis_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        in_set;
        logic [15:0] rounds;
        logic [1:0]  status;
    } t_mis_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [1:0]  i_operation;
    logic [12:0] i_index;
    logic [13:0] i_value;
    logic        o_valid, i_stall;
    logic        o_in_set;
    logic [15:0] o_rounds;
    logic [1:0]  o_status;

    randomized_mis_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_index(i_index), .i_value(i_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_in_set(o_in_set), .o_rounds(o_rounds), .o_status(o_status)
    );

    // mirror of the engine state
    int unsigned    offset_mem [0:rmis_pkg::C_MAX_VERTICES];
    int unsigned    target_mem [0:rmis_pkg::C_MAX_EDGES-1];
    int             desire_q   [0:rmis_pkg::C_MAX_VERTICES-1];
    int             desire_nx  [0:rmis_pkg::C_MAX_VERTICES-1];
    bit             active_q   [0:rmis_pkg::C_MAX_VERTICES-1];
    bit             commit_q   [0:rmis_pkg::C_MAX_VERTICES-1];
    bit             member_q   [0:rmis_pkg::C_MAX_VERTICES-1];
    logic [31:0]    lfsr_q;
    int unsigned    round_q;

    logic [10:0]    cfg_count;
    logic [3:0]     cfg_thresh;
    logic [5:0]     cfg_init;
    logic [5:0]     cfg_min;
    logic [31:0]    cfg_seed;
    logic [15:0]    cfg_max_rounds;

    t_mis_result    pending_results [$];
    int             mismatch_count;
    int             item_count;
    bit             calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned weight_of(int d);
        int s;
        s = rmis_pkg::C_FRACTION_BITS + d;
        if (s < 0) return 0;
        return longint'(1) << s;
    endfunction

    function automatic void edge_bounds(int v, output int unsigned lo,
                                        output int unsigned hi);
        lo = offset_mem[v];
        hi = offset_mem[v+1];
        if (lo > rmis_pkg::C_MAX_EDGES) lo = rmis_pkg::C_MAX_EDGES;
        if (hi > rmis_pkg::C_MAX_EDGES) hi = rmis_pkg::C_MAX_EDGES;
        if (hi < lo) hi = lo;
    endfunction

    function automatic void mis_round(int n, int dlow);
        int unsigned lo, hi, t;
        longint unsigned sum;
        bit still;
        for (int i = 0; i < n; i++) commit_q[i] = 0;
        for (int i = 0; i < n; i++) begin
            if (!active_q[i]) continue;
            lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? rmis_pkg::C_LFSR_MASK : 32'd0);
            if (longint'(lfsr_q >> (32 - rmis_pkg::C_FRACTION_BITS))
                < weight_of(desire_q[i]))
                commit_q[i] = 1;
            sum = 0;
            edge_bounds(i, lo, hi);
            for (int unsigned e = lo; e < hi; e++) begin
                t = target_mem[e];
                if (t < n && active_q[t]) sum += weight_of(desire_q[t]);
            end
            if (sum >= (longint'(cfg_thresh) << rmis_pkg::C_FRACTION_BITS))
                desire_nx[i] = (desire_q[i] - 1 < dlow) ? dlow : desire_q[i] - 1;
            else
                desire_nx[i] = (desire_q[i] + 1 > -1) ? -1 : desire_q[i] + 1;
        end
        for (int i = 0; i < n; i++) begin
            if (!commit_q[i]) continue;
            still = 1;
            edge_bounds(i, lo, hi);
            for (int unsigned e = lo; e < hi; e++) begin
                t = target_mem[e];
                if (t >= n) continue;
                if (member_q[t]) begin
                    active_q[i] = 0;
                    still = 0;
                end
                if (commit_q[t]) still = 0;
            end
            if (still) begin
                active_q[i] = 0;
                member_q[i] = 1;
            end
        end
        for (int i = 0; i < n; i++) desire_q[i] = desire_nx[i];
    endfunction

    function automatic logic [1:0] solve_mis();
        int n, dlow, d0;
        bit any;
        n = (cfg_count > rmis_pkg::C_MAX_VERTICES) ? rmis_pkg::C_MAX_VERTICES
                                                   : int'(cfg_count);
        dlow = ($signed(cfg_min) > -1) ? -1 : int'($signed(cfg_min));
        d0 = ($signed(cfg_init) > 0) ? 0 : int'($signed(cfg_init));
        if (d0 < dlow) d0 = dlow;
        for (int i = 0; i < rmis_pkg::C_MAX_VERTICES; i++) begin
            member_q[i] = 0;
            commit_q[i] = 0;
            active_q[i] = (i < n);
            desire_q[i] = d0;
            desire_nx[i] = d0;
        end
        lfsr_q = (cfg_seed != 0) ? cfg_seed : 32'd1;
        round_q = 0;
        forever begin
            any = 0;
            for (int i = 0; i < n; i++) if (active_q[i]) any = 1;
            if (!any) return rmis_pkg::STATUS_OK;
            if (round_q >= cfg_max_rounds) return rmis_pkg::STATUS_LIMIT;
            mis_round(n, dlow);
            round_q++;
        end
    endfunction

    function automatic t_mis_result predict_result(logic [1:0] op, logic [12:0] idx,
                                                   logic [13:0] val);
        t_mis_result r;
        int n;
        n = (cfg_count > rmis_pkg::C_MAX_VERTICES) ? rmis_pkg::C_MAX_VERTICES
                                                   : int'(cfg_count);
        r = '0;
        case (op)
            rmis_pkg::OP_LOAD_OFFSET: begin
                if (idx <= rmis_pkg::C_MAX_VERTICES) offset_mem[idx] = val;
                else r.status = rmis_pkg::STATUS_RANGE;
            end
            rmis_pkg::OP_LOAD_EDGE: begin
                if (idx < rmis_pkg::C_MAX_EDGES && val < rmis_pkg::C_MAX_VERTICES)
                    target_mem[idx] = val;
                else r.status = rmis_pkg::STATUS_RANGE;
            end
            rmis_pkg::OP_RUN: r.status = solve_mis();
            default: begin
                if (idx < n) r.in_set = member_q[idx];
                else r.status = rmis_pkg::STATUS_RANGE;
            end
        endcase
        r.rounds = round_q[15:0];
        return r;
    endfunction

    task automatic send_item(logic [1:0] op, int idx, int val);
        while (!calm && $urandom_range(0, 99) < 16) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_index     <= 13'(idx);
        i_value     <= 14'(val);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_result(op, 13'(idx), 14'(val)));
        item_count++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] reg_idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            rmis_pkg::REG_VERTEX_COUNT: cfg_count      = data[10:0];
            rmis_pkg::REG_DEG_THRESH:   cfg_thresh     = data[3:0];
            rmis_pkg::REG_INIT_DESIRE:  cfg_init       = data[5:0];
            rmis_pkg::REG_MIN_DESIRE:   cfg_min        = data[5:0];
            rmis_pkg::REG_SEED:         cfg_seed       = data;
            default:                    cfg_max_rounds = data[15:0];
        endcase
    endtask

    task automatic configure(int n, int thr, int init_d, int min_d, logic [31:0] seed,
                             int max_r);
        wait_idle();
        write_reg(rmis_pkg::REG_VERTEX_COUNT, n);
        write_reg(rmis_pkg::REG_DEG_THRESH, thr);
        write_reg(rmis_pkg::REG_INIT_DESIRE, init_d);
        write_reg(rmis_pkg::REG_MIN_DESIRE, min_d);
        write_reg(rmis_pkg::REG_SEED, seed);
        write_reg(rmis_pkg::REG_MAX_ROUNDS, max_r);
    endtask

    // csr graph with random degrees, some edges point beyond the count
    task automatic load_graph(int n, int base, bit noisy);
        int pos, deg;
        pos = base;
        for (int v = 0; v < n; v++) begin
            deg = $urandom_range(0, 4);
            send_item(rmis_pkg::OP_LOAD_OFFSET, v, pos);
            for (int k = 0; k < deg; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(rmis_pkg::OP_LOAD_EDGE, pos,
                              $urandom_range(n, rmis_pkg::C_MAX_VERTICES - 1));
                else
                    send_item(rmis_pkg::OP_LOAD_EDGE, pos, $urandom_range(0, n - 1));
                pos++;
                if (noisy && $urandom_range(0, 7) == 0) begin
                    if ($urandom_range(0, 1))
                        send_item(rmis_pkg::OP_LOAD_OFFSET,
                                  $urandom_range(rmis_pkg::C_MAX_VERTICES + 1, 8191),
                                  $urandom_range(0, 16383));
                    else
                        send_item(rmis_pkg::OP_LOAD_EDGE, $urandom_range(0, 8191),
                                  $urandom_range(rmis_pkg::C_MAX_VERTICES, 16383));
                end
            end
        end
        send_item(rmis_pkg::OP_LOAD_OFFSET, n, pos);
    endtask

    task automatic read_all(int n);
        for (int v = 0; v <= n; v++)
            send_item(rmis_pkg::OP_READ_VERTEX, v, $urandom_range(0, 16383));
    endtask

    task automatic test_setup();
        configure(4, 2, -1, -24, 32'd4, 65535);
        for (int s = 0; s <= rmis_pkg::C_MAX_VERTICES; s++) begin
            calm = (s < 300);
            send_item(rmis_pkg::OP_LOAD_OFFSET, s, 0);
        end
        calm = 0;
    endtask

    task automatic test_directed();
        // lone vertex and range errors on load offset, load edge and read vertex
        configure(1, 2, -1, -24, 32'd0, 16);
        send_item(rmis_pkg::OP_RUN, 0, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 0, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 1, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 8191, 16383);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 8191, 16383);
        send_item(rmis_pkg::OP_LOAD_OFFSET, rmis_pkg::C_MAX_VERTICES + 1, 0);
        send_item(rmis_pkg::OP_LOAD_EDGE, 8191, rmis_pkg::C_MAX_VERTICES);
        send_item(rmis_pkg::OP_LOAD_EDGE, 0, 16383);
        // offsets past the edge store and an end below its start
        configure(3, 1, 5, 7, 32'hFFFF_FFFF, 65535);
        send_item(rmis_pkg::OP_LOAD_EDGE, 8190, 1);
        send_item(rmis_pkg::OP_LOAD_EDGE, 8191, 0);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 0, 8190);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 1, 16383);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 2, 5);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 3, 5);
        send_item(rmis_pkg::OP_RUN, 0, 0);
        read_all(3);
        // self loop and neighbour beyond the count, tight round limit
        configure(2, 15, -24, -24, 32'h1234_5678, 1);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 0, 0);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 1, 2);
        send_item(rmis_pkg::OP_LOAD_OFFSET, 2, 3);
        send_item(rmis_pkg::OP_LOAD_EDGE, 0, 0);
        send_item(rmis_pkg::OP_LOAD_EDGE, 1, 1000);
        send_item(rmis_pkg::OP_LOAD_EDGE, 2, 1);
        send_item(rmis_pkg::OP_RUN, 0, 0);
        // empty graph
        configure(0, 2, 0, -1, 32'd4, 4096);
        send_item(rmis_pkg::OP_RUN, 0, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 0, 0);
    endtask

    task automatic test_full_count();
        configure(2047, 2, -1, -24, $urandom, 65535);
        for (int s = 0; s < 17; s++) send_item(rmis_pkg::OP_LOAD_OFFSET, s, 0);
        send_item(rmis_pkg::OP_RUN, 0, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 1023, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, 1024, 0);
        send_item(rmis_pkg::OP_READ_VERTEX, $urandom_range(0, 1023), 0);
    endtask

    task automatic test_random();
        int n, phase, stop_at;
        phase = 0;
        stop_at = item_count + 76;
        while (item_count < stop_at) begin
            calm = (phase >= 8 && phase < 14);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            configure(n, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 15),
                      $urandom_range(0, 3) == 0 ? $urandom : -$urandom_range(0, 24),
                      $urandom_range(0, 3) == 0 ? $urandom : -$urandom_range(1, 24),
                      $urandom,
                      $urandom_range(0, 4) == 0 ? $urandom_range(1, 4)
                                                : $urandom_range(64, 1024));
            load_graph(n, $urandom_range(0, rmis_pkg::C_MAX_EDGES - 200), 1);
            send_item(rmis_pkg::OP_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383));
            for (int k = 0; k < n / 2 + 1; k++)
                send_item(rmis_pkg::OP_READ_VERTEX,
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                          : $urandom_range(0, n - 1), $urandom_range(0, 16383));
            if ($urandom_range(0, 2) == 0) send_item(rmis_pkg::OP_RUN, 0, 0);
            phase++;
        end
        calm = 0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    always @(posedge i_clk) begin
        t_mis_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transfer at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (o_in_set !== want.in_set || o_rounds !== want.rounds
                    || o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("mismatch at %0t: expected in_set %0d rounds %0d status %0d, ",
                               $realtime, want.in_set, want.rounds, want.status);
                        $display("got in_set %0d rounds %0d status %0d",
                                 o_in_set, o_rounds, o_status);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_operation = rmis_pkg::OP_LOAD_OFFSET; i_index = '0; i_value = '0;
        i_stall = 1'b0;
        calm = 0; mismatch_count = 0; item_count = 0;
        cfg_count = 1; cfg_thresh = 2; cfg_init = 6'h3F; cfg_min = 6'h28;
        cfg_seed = 4; cfg_max_rounds = 4096;
        lfsr_q = 0; round_q = 0;
        for (int i = 0; i < rmis_pkg::C_MAX_VERTICES; i++) begin
            desire_q[i] = 0; desire_nx[i] = 0;
            active_q[i] = 0; commit_q[i] = 0; member_q[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_setup();
        test_directed();
        test_full_count();
        test_random();
        wait_idle();
        if (pending_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== randomized_mis_engine.f =====
rtl/rmis_pkg.sv
rtl/randomized_mis_engine.sv
tb/randomized_mis_engine_tb.sv
